FILE: hdl/aapr_pkg.sv
`timescale 1ns / 1ps
// aapr_pkg: shared types and constants of the axis-angle point rotation unit
// no dependencies; used by aapr_sine, the top level and the bench

package aapr_pkg;

	// q30 fixed point, one equals 2^30
	localparam int Q30_SHIFT = 30;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	// horner evaluation of sin(pi/2*x): one square stage, five horner stages, one final product
	localparam int HORNER_STEPS = 5;
	localparam int SINE_STAGES = HORNER_STEPS + 2;

	// taylor coefficients of sin(pi/2*x) in q30, innermost first
	localparam logic [30:0] SINE_K [0:HORNER_STEPS] = '{
		31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
	};

	// matrix entry width, q30 signed
	localparam int ENTRY_WIDTH = 36;

	typedef enum logic [1:0] {
		QUAD_I,
		QUAD_II,
		QUAD_III,
		QUAD_IV
	} quad_t;

	typedef struct packed {
		logic [30:0] sin_a;
		logic [30:0] sin_b;
		quad_t       quad;
	} sine_res_t;

endpackage

FILE: hdl/aapr_in_if.sv
`timescale 1ns / 1ps
// aapr_in_if: input channel of the rotation unit, one point per transfer
// no dependencies

interface aapr_in_if #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] point_x;
	logic signed [COORD_WIDTH-1:0] point_y;
	logic signed [COORD_WIDTH-1:0] point_z;
	logic signed [COORD_WIDTH-1:0] pivot_x;
	logic signed [COORD_WIDTH-1:0] pivot_y;
	logic signed [COORD_WIDTH-1:0] pivot_z;
	logic signed [15:0]            axis_x;
	logic signed [15:0]            axis_y;
	logic signed [15:0]            axis_z;
	logic signed [ANGLE_WIDTH-1:0] turn_angle;

	modport source (
		output valid, point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
		output axis_x, axis_y, axis_z, turn_angle,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
		input  axis_x, axis_y, axis_z, turn_angle,
		output ready
	);
endinterface

FILE: hdl/aapr_out_if.sv
`timescale 1ns / 1ps
// aapr_out_if: result channel of the rotation unit, one rotated point per transfer
// no dependencies

interface aapr_out_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] rotated_x;
	logic signed [COORD_WIDTH-1:0] rotated_y;
	logic signed [COORD_WIDTH-1:0] rotated_z;
	logic                          clipped;

	modport source (
		output valid, rotated_x, rotated_y, rotated_z, clipped,
		input  ready
	);
	modport sink (
		input  valid, rotated_x, rotated_y, rotated_z, clipped,
		output ready
	);
endinterface

FILE: hdl/aapr_sine.sv
`timescale 1ns / 1ps
// aapr_sine: pipelined quarter-wave sine of the phase and of its complement
// depends on aapr_pkg

module aapr_sine #(
	parameter int ANGLE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic [aapr_pkg::SINE_STAGES-1:0] en,
	input  logic [ANGLE_WIDTH-1:0]           angle,
	output aapr_pkg::sine_res_t              res
);

	localparam int NS = aapr_pkg::SINE_STAGES;

	logic [30:0] xa_s [1:NS-1];
	logic [30:0] xb_s [1:NS-1];
	logic [30:0] za_s [1:NS-2];
	logic [30:0] zb_s [1:NS-2];
	logic [30:0] pa_s [2:NS-1];
	logic [30:0] pb_s [2:NS-1];
	aapr_pkg::quad_t quad_s [1:NS-1];

	logic [30:0] xa0, xb0;
	logic [61:0] sqa, sqb;

	// phase: top two angle bits pick the quadrant, the rest is x in q30
	assign xa0 = {1'b0, angle[ANGLE_WIDTH-3:0], {(32-ANGLE_WIDTH){1'b0}}};
	assign xb0 = aapr_pkg::Q30_ONE - xa0;
	assign sqa = {31'b0, xa0} * {31'b0, xa0};
	assign sqb = {31'b0, xb0} * {31'b0, xb0};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			xa_s[1]   <= xa0;
			xb_s[1]   <= xb0;
			za_s[1]   <= sqa[60:30];
			zb_s[1]   <= sqb[60:30];
			quad_s[1] <= aapr_pkg::quad_t'(angle[ANGLE_WIDTH-1:ANGLE_WIDTH-2]);
		end
	end

	// horner steps, one coefficient per stage
	for (genvar k = 2; k <= NS - 1; k++) begin : g_horner
		logic [30:0] pa_in, pb_in;
		logic [61:0] prod_a, prod_b;

		if (k == 2) begin : g_first
			assign pa_in = aapr_pkg::SINE_K[0];
			assign pb_in = aapr_pkg::SINE_K[0];
		end else begin : g_next
			assign pa_in = pa_s[k-1];
			assign pb_in = pb_s[k-1];
		end

		assign prod_a = {31'b0, pa_in} * {31'b0, za_s[k-1]};
		assign prod_b = {31'b0, pb_in} * {31'b0, zb_s[k-1]};

		always_ff @(posedge clk) begin
			if (en[k-1]) begin
				pa_s[k]   <= aapr_pkg::SINE_K[k-1] - prod_a[60:30];
				pb_s[k]   <= aapr_pkg::SINE_K[k-1] - prod_b[60:30];
				xa_s[k]   <= xa_s[k-1];
				xb_s[k]   <= xb_s[k-1];
				quad_s[k] <= quad_s[k-1];
			end
		end

		if (k <= NS - 2) begin : g_zcarry
			always_ff @(posedge clk) begin
				if (en[k-1]) begin
					za_s[k] <= za_s[k-1];
					zb_s[k] <= zb_s[k-1];
				end
			end
		end
	end

	// final product, round half up and clamp to one
	logic [61:0] fa, fb;
	logic [30:0] sa, sb;

	assign fa = {31'b0, pa_s[NS-1]} * {31'b0, xa_s[NS-1]} + 62'h2000_0000;
	assign fb = {31'b0, pb_s[NS-1]} * {31'b0, xb_s[NS-1]} + 62'h2000_0000;
	assign sa = (fa[61:30] > {1'b0, aapr_pkg::Q30_ONE}) ? aapr_pkg::Q30_ONE : fa[60:30];
	assign sb = (fb[61:30] > {1'b0, aapr_pkg::Q30_ONE}) ? aapr_pkg::Q30_ONE : fb[60:30];

	always_ff @(posedge clk) begin
		if (en[NS-1]) begin
			res.sin_a <= sa;
			res.sin_b <= sb;
			res.quad  <= quad_s[NS-1];
		end
	end

endmodule

FILE: hdl/axis_angle_point_rotation_unit.sv
`timescale 1ns / 1ps
// axis_angle_point_rotation_unit: rodrigues rotation of a point about an axis through a pivot
// depends on aapr_pkg, aapr_sine, aapr_in_if, aapr_out_if
// results leave in the order of the input transfers, one item per clock sustained while the
// output is ready
// the thirteen register stages each hold a valid bit; a stage takes new data when it is
// empty or moving on, so bubbles close up behind a stalled output
// asynchronous active-low reset clears all valid bits; data registers are not reset

module axis_angle_point_rotation_unit #(
	parameter int COORD_WIDTH = 32,
	parameter int ANGLE_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	aapr_in_if.sink    point_in,
	aapr_out_if.source point_out
);

	// stage map
	//   1      d = point - pivot, axis products ai*aj, phase square (sine unit)
	//   2..6   horner steps (sine unit)
	//   7      final sine product and clamp (sine unit)
	//   8      quadrant select: sin, cos, k = 1 - cos
	//   9      (ai*aj)*k and ai*sin, rounded to q30
	//   10     matrix entries
	//   11     entry times difference, split into two partial products
	//   12     row sums plus rounding bias
	//   13     shift, add pivot, saturate (output register)
	localparam int NS    = 13;
	localparam int SS    = aapr_pkg::SINE_STAGES;
	localparam int DW    = COORD_WIDTH + 1;
	localparam int SPLIT = (DW + 1) / 2;
	localparam int HW    = DW - SPLIT;
	localparam int EW    = aapr_pkg::ENTRY_WIDTH;
	localparam int PHW   = EW + HW;
	localparam int PLW   = EW + SPLIT + 1;
	localparam int SW    = EW + DW + 2;
	localparam int RW    = SW - 29;

	localparam logic signed [RW-1:0] CMAX = {{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [RW-1:0] CMIN = ~CMAX;

	// handshake: stage i loads when empty or when stage i+1 loads
	logic [NS:1]   vld_q;
	logic [NS+1:1] en;

	always_comb begin
		en[NS+1] = point_out.ready;
		for (int i = NS; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign point_in.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= point_in.valid;
			for (int i = 2; i <= NS; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// sine unit occupies stages 1..7
	aapr_pkg::sine_res_t sine_res;

	aapr_sine #(
		.ANGLE_WIDTH(ANGLE_WIDTH)
	) u_sine (
		.clk  (clk),
		.en   (en[SS:1]),
		.angle(point_in.turn_angle),
		.res  (sine_res)
	);

	// payload that travels beside the sine unit
	logic signed [DW-1:0]          d_s   [1:10][3];
	logic signed [COORD_WIDTH-1:0] piv_s [1:12][3];
	logic signed [15:0]            ax_s  [1:8][3];
	logic signed [31:0]            aij_s [1:8][6];

	logic signed [COORD_WIDTH-1:0] pt_in [3];
	logic signed [COORD_WIDTH-1:0] pv_in [3];
	logic signed [15:0]            ax_in [3];

	assign pt_in = '{point_in.point_x, point_in.point_y, point_in.point_z};
	assign pv_in = '{point_in.pivot_x, point_in.pivot_y, point_in.pivot_z};
	assign ax_in = '{point_in.axis_x, point_in.axis_y, point_in.axis_z};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int j = 0; j < 3; j++) begin
				d_s[1][j]   <= pt_in[j] - pv_in[j];
				piv_s[1][j] <= pv_in[j];
				ax_s[1][j]  <= ax_in[j];
			end
			// xx, yy, zz, xy, xz, yz
			aij_s[1][0] <= ax_in[0] * ax_in[0];
			aij_s[1][1] <= ax_in[1] * ax_in[1];
			aij_s[1][2] <= ax_in[2] * ax_in[2];
			aij_s[1][3] <= ax_in[0] * ax_in[1];
			aij_s[1][4] <= ax_in[0] * ax_in[2];
			aij_s[1][5] <= ax_in[1] * ax_in[2];
		end
		for (int i = 2; i <= 12; i++) begin
			if (en[i]) piv_s[i] <= piv_s[i-1];
		end
		for (int i = 2; i <= 10; i++) begin
			if (en[i]) d_s[i] <= d_s[i-1];
		end
		for (int i = 2; i <= 8; i++) begin
			if (en[i]) begin
				ax_s[i]  <= ax_s[i-1];
				aij_s[i] <= aij_s[i-1];
			end
		end
	end

	// stage 8: quadrant signs
	logic signed [31:0] sa, sb, sin_v, cos_v;
	logic signed [31:0] sin_s8, cos_s8;
	logic signed [32:0] k_s8;

	assign sa = $signed({1'b0, sine_res.sin_a});
	assign sb = $signed({1'b0, sine_res.sin_b});

	always_comb begin
		case (sine_res.quad)
			aapr_pkg::QUAD_I: begin
				sin_v = sa;
				cos_v = sb;
			end
			aapr_pkg::QUAD_II: begin
				sin_v = sb;
				cos_v = -sa;
			end
			aapr_pkg::QUAD_III: begin
				sin_v = -sa;
				cos_v = -sb;
			end
			default: begin
				sin_v = -sb;
				cos_v = sa;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			sin_s8 <= sin_v;
			cos_s8 <= cos_v;
			k_s8   <= $signed({2'b00, aapr_pkg::Q30_ONE}) - cos_v;
		end
	end

	// stage 9: outer product scaled by k, cross terms scaled by sin, round to nearest
	logic signed [64:0] ak_full [6];
	logic signed [47:0] as_full [3];
	logic signed [34:0] ak_s9 [6];
	logic signed [32:0] as_s9 [3];
	logic signed [31:0] cos_s9;

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			ak_full[j] = aij_s[8][j] * k_s8 + 65'sh2000_0000;
		end
		for (int j = 0; j < 3; j++) begin
			as_full[j] = ax_s[8][j] * sin_s8 + 48'sh4000;
		end
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			for (int j = 0; j < 6; j++) ak_s9[j] <= $signed(ak_full[j][64:30]);
			for (int j = 0; j < 3; j++) as_s9[j] <= $signed(as_full[j][47:15]);
			cos_s9 <= cos_s8;
		end
	end

	// stage 10: matrix entries c*I + k*A*A^T + s*[A]x
	logic signed [EW-1:0] m_s10 [3][3];

	always_ff @(posedge clk) begin
		if (en[10]) begin
			m_s10[0][0] <= ak_s9[0] + cos_s9;
			m_s10[0][1] <= ak_s9[3] - as_s9[2];
			m_s10[0][2] <= ak_s9[4] + as_s9[1];
			m_s10[1][0] <= ak_s9[3] + as_s9[2];
			m_s10[1][1] <= ak_s9[1] + cos_s9;
			m_s10[1][2] <= ak_s9[5] - as_s9[0];
			m_s10[2][0] <= ak_s9[4] - as_s9[1];
			m_s10[2][1] <= ak_s9[5] + as_s9[0];
			m_s10[2][2] <= ak_s9[2] + cos_s9;
		end
	end

	// stage 11: each entry times the high and low halves of the difference
	logic signed [PHW-1:0] ph_s11 [3][3];
	logic signed [PLW-1:0] pl_s11 [3][3];

	always_ff @(posedge clk) begin
		if (en[11]) begin
			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					ph_s11[r][j] <= m_s10[r][j] * $signed(d_s[10][j][DW-1:SPLIT]);
					pl_s11[r][j] <= m_s10[r][j] * $signed({1'b0, d_s[10][j][SPLIT-1:0]});
				end
			end
		end
	end

	// stage 12: row sums with the half-lsb rounding bias folded in
	logic signed [SW-1:0] row_sum [3];

	always_comb begin
		logic signed [SW-1:0] hx, lx;
		for (int r = 0; r < 3; r++) begin
			row_sum[r] = SW'(1) <<< (aapr_pkg::Q30_SHIFT - 1);
			for (int j = 0; j < 3; j++) begin
				hx = ph_s11[r][j];
				lx = pl_s11[r][j];
				row_sum[r] = row_sum[r] + (hx <<< SPLIT) + lx;
			end
		end
	end

	logic signed [SW-1:0] sum_s12 [3];

	always_ff @(posedge clk) begin
		if (en[12]) sum_s12 <= row_sum;
	end

	// stage 13: drop the q30 fraction, add pivot, saturate
	logic signed [RW-1:0]          res_full [3];
	logic signed [COORD_WIDTH-1:0] res_sat  [3];
	logic [2:0]                    res_clip;
	logic signed [COORD_WIDTH-1:0] rot_s13  [3];
	logic                          clip_s13;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			res_full[r] = $signed(sum_s12[r][SW-1:aapr_pkg::Q30_SHIFT]) + piv_s[12][r];
			if (res_full[r] > CMAX) begin
				res_sat[r]  = CMAX[COORD_WIDTH-1:0];
				res_clip[r] = 1'b1;
			end else if (res_full[r] < CMIN) begin
				res_sat[r]  = CMIN[COORD_WIDTH-1:0];
				res_clip[r] = 1'b1;
			end else begin
				res_sat[r]  = res_full[r][COORD_WIDTH-1:0];
				res_clip[r] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[13]) begin
			rot_s13  <= res_sat;
			clip_s13 <= |res_clip;
		end
	end

	assign point_out.valid     = vld_q[NS];
	assign point_out.rotated_x = rot_s13[0];
	assign point_out.rotated_y = rot_s13[1];
	assign point_out.rotated_z = rot_s13[2];
	assign point_out.clipped   = clip_s13;

	// a free output lets every stage move, so the input is open
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		point_out.ready |-> point_in.ready)
		else $error("input not ready while output is free");

	// an item in the last data stage reaches the output when it may move
	a_last_moves: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[NS-1] && en[NS] |=> point_out.valid)
		else $error("item lost before output register");

	// a clipped result holds a rail value in some coordinate
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		point_out.valid && point_out.clipped |->
			(rot_s13[0] == CMAX[COORD_WIDTH-1:0]) || (rot_s13[0] == CMIN[COORD_WIDTH-1:0]) ||
			(rot_s13[1] == CMAX[COORD_WIDTH-1:0]) || (rot_s13[1] == CMIN[COORD_WIDTH-1:0]) ||
			(rot_s13[2] == CMAX[COORD_WIDTH-1:0]) || (rot_s13[2] == CMIN[COORD_WIDTH-1:0]))
		else $error("clipped set without saturated coordinate");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for axis_angle_point_rotation_unit, rodrigues rotation about a pivot
// depends on aapr_pkg, aapr_in_if, aapr_out_if and the unit itself; predicts every result

module tb;

	localparam int CW = 32;
	localparam int AW = 16;
	localparam int ITEM_COUNT = 400;
	localparam int CALM_TAIL = 60;

	typedef struct {
		logic signed [CW-1:0] pt [3];
		logic signed [CW-1:0] pv [3];
		logic signed [15:0]   ax [3];
		logic signed [AW-1:0] ang;
		bit                   drain_first;
	} vertex_t;

	typedef struct {
		logic signed [CW-1:0] r [3];
		logic                 clipped;
	} rotated_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	aapr_in_if  #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) pin ();
	aapr_out_if #(.COORD_WIDTH(CW)) pout ();

	axis_angle_point_rotation_unit #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.point_in (pin.sink),
		.point_out(pout.source)
	);

	vertex_t  vertex_q [$];
	rotated_t rotated_q [$];
	vertex_t  on_bus;
	int       sent = 0;
	int       seen = 0;
	int       mismatches = 0;
	int       send_gap = 0;
	int       recv_gap = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// sin(pi/2*x), x and result q30, horner with floored inner products
	function automatic longint unsigned quarter_wave(longint unsigned x);
		longint unsigned z, p, r;
		z = (x * x) >> 30;
		p = 64'(aapr_pkg::SINE_K[0]);
		for (int i = 1; i <= aapr_pkg::HORNER_STEPS; i++)
			p = 64'(aapr_pkg::SINE_K[i]) - ((p * z) >> 30);
		r = (p * x + (64'd1 << 29)) >> 30;
		if (r > (64'd1 << 30))
			r = 64'd1 << 30;
		return r;
	endfunction

	// round to nearest, ties up
	function automatic longint rnd_shift(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic rotated_t rotate_vertex(vertex_t v);
		rotated_t res;
		logic [31:0] phase;
		longint unsigned frac;
		longint sa, sb, s, c, k, a [3], m [3][3], xs, ys, zs;
		logic signed [127:0] acc, ee, dd, lim_hi, lim_lo;
		lim_hi = (128'sd1 <<< (CW - 1)) - 1;
		lim_lo = -lim_hi - 1;
		phase = 32'(v.ang) << (32 - AW);
		frac = 64'(phase[29:0]);
		sa = quarter_wave(frac);
		sb = quarter_wave((64'd1 << 30) - frac);
		case (aapr_pkg::quad_t'(phase[31:30]))
			aapr_pkg::QUAD_I: begin
				s = sa; c = sb;
			end
			aapr_pkg::QUAD_II: begin
				s = sb; c = -sa;
			end
			aapr_pkg::QUAD_III: begin
				s = -sa; c = -sb;
			end
			default: begin
				s = -sb; c = sa;
			end
		endcase
		k = (64'sd1 <<< 30) - c;
		for (int i = 0; i < 3; i++)
			a[i] = v.ax[i];
		// symmetric part (1-c)*a*a^T plus c on the diagonal
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				m[i][j] = rnd_shift(a[i] * a[j] * k, 30) + ((i == j) ? c : 0);
		// skew part s*[a]x
		xs = rnd_shift(a[0] * s, 15);
		ys = rnd_shift(a[1] * s, 15);
		zs = rnd_shift(a[2] * s, 15);
		m[0][1] -= zs; m[1][0] += zs;
		m[0][2] += ys; m[2][0] -= ys;
		m[1][2] -= xs; m[2][1] += xs;
		res.clipped = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) begin
				ee = m[i][j];
				dd = 128'(v.pt[j]) - 128'(v.pv[j]);
				acc += ee * dd;
			end
			acc = ((acc + (128'sd1 <<< 29)) >>> 30) + 128'(v.pv[i]);
			if (acc > lim_hi) begin
				acc = lim_hi; res.clipped = 1'b1;
			end
			if (acc < lim_lo) begin
				acc = lim_lo; res.clipped = 1'b1;
			end
			res.r[i] = acc[CW-1:0];
		end
		return res;
	endfunction

	// random vertex: unit axis most of the time, coordinates small or full range
	function automatic vertex_t random_vertex();
		vertex_t v;
		real f [3], len;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			len = 0.0;
			for (int i = 0; i < 3; i++) begin
				f[i] = $itor($signed($urandom_range(0, 2000)) - 1000);
				len += f[i] * f[i];
			end
			if (len == 0.0) begin
				f[0] = 1.0; len = 1.0;
			end
			len = $sqrt(len);
			for (int i = 0; i < 3; i++)
				v.ax[i] = 16'($rtoi(f[i] / len * 32767.0));
		end else if (pick < 8) begin
			for (int i = 0; i < 3; i++)
				v.ax[i] = 16'(0);
			v.ax[$urandom_range(0, 2)] = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
		end else begin
			for (int i = 0; i < 3; i++)
				v.ax[i] = 16'($urandom);
		end
		for (int i = 0; i < 3; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				v.pt[i] = $urandom;
				v.pv[i] = $urandom;
			end else begin
				v.pt[i] = CW'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
				v.pv[i] = CW'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			end
		end
		v.ang = AW'($urandom);
		v.drain_first = 1'b0;
		return v;
	endfunction

	function automatic vertex_t set_vertex(longint p, longint o, logic signed [15:0] x,
		logic signed [15:0] y, logic signed [15:0] z, logic signed [AW-1:0] an);
		vertex_t v;
		for (int i = 0; i < 3; i++) begin
			v.pt[i] = CW'(p + i * 65536);
			v.pv[i] = CW'(o);
		end
		v.ax[0] = x; v.ax[1] = y; v.ax[2] = z;
		v.ang = an;
		v.drain_first = 1'b0;
		return v;
	endfunction

	// sender: drives the front of vertex_q, random idle bursts except near the end
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin.valid      <= 1'b0;
			pin.point_x    <= '0;
			pin.point_y    <= '0;
			pin.point_z    <= '0;
			pin.pivot_x    <= '0;
			pin.pivot_y    <= '0;
			pin.pivot_z    <= '0;
			pin.axis_x     <= '0;
			pin.axis_y     <= '0;
			pin.axis_z     <= '0;
			pin.turn_angle <= '0;
		end else begin
			if (pin.valid && pin.ready) begin
				rotated_q.push_back(rotate_vertex(on_bus));
				sent++;
			end
			if (!(pin.valid && !pin.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					pin.valid <= 1'b0;
				end else if (vertex_q.size() == 0 ||
					(vertex_q[0].drain_first && rotated_q.size() != 0)) begin
					// nothing to send, or a pause until the pipe is empty
					pin.valid <= 1'b0;
				end else begin
					on_bus = vertex_q.pop_front();
					pin.valid      <= 1'b1;
					pin.point_x    <= on_bus.pt[0];
					pin.point_y    <= on_bus.pt[1];
					pin.point_z    <= on_bus.pt[2];
					pin.pivot_x    <= on_bus.pv[0];
					pin.pivot_y    <= on_bus.pv[1];
					pin.pivot_z    <= on_bus.pv[2];
					pin.axis_x     <= on_bus.ax[0];
					pin.axis_y     <= on_bus.ax[1];
					pin.axis_z     <= on_bus.ax[2];
					pin.turn_angle <= on_bus.ang;
					if (vertex_q.size() > CALM_TAIL && $urandom_range(0, 11) == 0)
						send_gap = $urandom_range(1, 19);
				end
			end
		end
	end

	// receiver: random stall bursts, checks every transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pout.ready <= 1'b0;
		end else begin
			if (pout.valid && pout.ready) begin
				seen++;
				if (rotated_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer x=%0d y=%0d z=%0d clipped=%0b",
							pout.rotated_x, pout.rotated_y, pout.rotated_z, pout.clipped);
				end else begin
					rotated_t want;
					want = rotated_q.pop_front();
					if (pout.rotated_x !== want.r[0] || pout.rotated_y !== want.r[1] ||
						pout.rotated_z !== want.r[2] || pout.clipped !== want.clipped) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected %0d %0d %0d clip %0b",
								seen, want.r[0], want.r[1], want.r[2], want.clipped,
								", got %0d %0d %0d clip %0b",
								pout.rotated_x, pout.rotated_y, pout.rotated_z, pout.clipped);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				pout.ready <= 1'b0;
			end else begin
				pout.ready <= 1'b1;
				if (sent < ITEM_COUNT - CALM_TAIL && $urandom_range(0, 11) == 0)
					recv_gap = $urandom_range(1, 19);
			end
		end
	end

	initial begin
		vertex_t v;
		int n;
		// identity angle, half turn both ways, quarter turns, zero axis, oversized axis
		vertex_q.push_back(set_vertex(65536, 0, 16'sd32767, 0, 0, 0));
		vertex_q.push_back(set_vertex(65536, 0, 0, 0, 16'sd32767, -16'sd32768));
		vertex_q.push_back(set_vertex(65536, 0, 0, 0, 16'sd32767, 16'sd32767));
		vertex_q.push_back(set_vertex(65536, 131072, 0, 16'sd32767, 0, 16'sd16384));
		vertex_q.push_back(set_vertex(-65536, 7, 16'sd32767, 0, 0, -16'sd16384));
		vertex_q.push_back(set_vertex(300000, -5000, 0, 0, 0, 16'sd5000));
		vertex_q.push_back(set_vertex(300000, 9, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd1));
		vertex_q.push_back(set_vertex(12345, 0, 16'sd32767, 16'sd32767, 16'sd32767, -16'sd1));
		// far corners: point and pivot at the extremes, opposite or alike, saturates
		vertex_q.push_back(set_vertex(longint'(32'h7fff_0000), -2147483648, 0, 0, 16'sd32767,
			-16'sd32768));
		vertex_q.push_back(set_vertex(-2147483648, 2147483647, 16'sd32767, 0, 0, 16'sd16384));
		vertex_q.push_back(set_vertex(2147483647, 2147483647, 0, 16'sd32767, 0, 16'sd8192));
		vertex_q.push_back(set_vertex(-2147483648, -2147483648, 0, 0, -16'sd32768, 16'sd100));
		v = set_vertex(2147483647, -2147483648, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd12000);
		vertex_q.push_back(v);
		// pause here until everything is back
		v = random_vertex();
		v.drain_first = 1'b1;
		vertex_q.push_back(v);
		n = vertex_q.size();
		for (int i = n; i < ITEM_COUNT; i++) begin
			v = random_vertex();
			v.drain_first = (i == ITEM_COUNT / 2);
			vertex_q.push_back(v);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (sent == ITEM_COUNT && rotated_q.size() == 0);
		repeat (30) @(posedge clk);
		if (mismatches == 0 && rotated_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
